// ----- sv/wcts_pkg.sv -----
// ----------------------------------------------------------------------------
// wcts_pkg
// Types, sizes and codes shared by the wall column texture shader.
// ----------------------------------------------------------------------------
package wcts_pkg;

    localparam int TEX_WIDTH     = 64;
    localparam int TEX_HEIGHT    = 64;
    localparam int TEXTURE_SLOTS = 2;
    localparam int MAX_ROWS      = 1024;

    localparam int STORE_DEPTH = TEXTURE_SLOTS * TEX_WIDTH * TEX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TX_W        = $clog2(TEX_WIDTH);
    localparam int TY_W        = $clog2(TEX_HEIGHT);
    localparam int TXP_W       = 16 + $clog2(TEX_WIDTH + 1);

    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int DIST_W     = 16;
    localparam int WALL_U_W   = 16;
    localparam int WTYPE_W    = 8;
    localparam int TEXCOORD_W = 6;
    localparam int TEXEL_W    = 24;
    localparam int COLOR_W    = 32;

    localparam int SCREEN_HEIGHT_W = 11;
    localparam int WALL_SCALE_W    = 12;
    localparam int TEXTURE_COUNT_W = 2;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALL_SCALE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXTURE_COUNT = 2'd2;

    localparam logic [SCREEN_HEIGHT_W-1:0] RESET_SCREEN_HEIGHT = 11'd480;
    localparam logic [WALL_SCALE_W-1:0]    RESET_WALL_SCALE    = 12'd360;
    localparam logic [TEXTURE_COUNT_W-1:0] RESET_TEXTURE_COUNT = 2'd2;

    // screen rows after clamping to MAX_ROWS
    localparam int HS_W = $clog2(MAX_ROWS + 1);
    // wall height: covers wall_scale * 256 / 4 and twice MAX_ROWS
    localparam int H_W   = WALL_SCALE_W + 6;
    localparam int TOP_W = H_W + 2;
    localparam int CMP_W = TOP_W + 1;

    localparam int DIV_NUM_W     = H_W + $clog2(TEX_HEIGHT + 1);
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STAGES    = (DIV_NUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_PAD_W     = DIV_STAGES * DIV_STEP_BITS;

    localparam logic CMD_TEXEL = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [WTYPE_W-1:0] WALL_BRICK = 8'd1;
    localparam logic [WTYPE_W-1:0] WALL_STONE = 8'd2;

    localparam logic [DIST_W-1:0]  NEAR_LIMIT   = 16'd3;
    localparam logic [TEXEL_W-1:0] GREY_RGB     = 24'h646464;
    localparam logic [TEXEL_W-1:0] HALF_MASK    = 24'h7F7F7F;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic                  cmd;
        logic [COL_W-1:0]      column;
        logic [ROW_W-1:0]      row;
        logic [DIST_W-1:0]     distance;
        logic [WALL_U_W-1:0]   wall_u;
        logic [WTYPE_W-1:0]    wall_type;
        logic                  vertical_face;
        logic                  tex_select;
        logic [TEXCOORD_W-1:0] tex_col;
        logic [TEXCOORD_W-1:0] tex_row;
        logic [TEXEL_W-1:0]    texel;
    } wcts_in_t;

    typedef struct packed {
        logic [COL_W-1:0]   out_column;
        logic [ROW_W-1:0]   out_row;
        logic [COLOR_W-1:0] pixel_color;
    } wcts_out_t;

endpackage

// ----- sv/wall_column_texture_shader.sv -----
// ----------------------------------------------------------------------------
// wall_column_texture_shader
// Throughput: one item per cycle while the skid entry is empty. Two pipelined
// 13-stage dividers (height, then texture row), two quotient bits per stage.
// A waiting result is held in an output register plus one skid entry.
// Reset: synchronous, active low; clears valid bits, reloads config defaults.
// The texel store is not cleared.
// ----------------------------------------------------------------------------
module wall_column_texture_shader import wcts_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  wcts_in_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output wcts_out_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef struct packed {
        wcts_in_t        item;
        logic [HS_W-1:0] hs;
        logic            near;
    } s1_t;

    typedef struct packed {
        logic                  cmd;
        logic [COL_W-1:0]      column;
        logic [ROW_W-1:0]      row;
        logic                  vface;
        logic                  tsel;
        logic [TEXCOORD_W-1:0] tcol;
        logic [TEXCOORD_W-1:0] trow;
        logic [TEXEL_W-1:0]    texel;
        logic                  slot;
        logic                  grey;
        logic [TX_W-1:0]       tx;
        logic                  draw;
        logic                  hzero;
    } ctx_t;

    logic [SCREEN_HEIGHT_W-1:0] cfg_screen_height_reg;
    logic [WALL_SCALE_W-1:0]    cfg_wall_scale_reg;
    logic [TEXTURE_COUNT_W-1:0] cfg_texture_count_reg;

    logic pipe_en;

    logic            a_valid_reg;
    s1_t             a_s1_reg;
    logic [HS_W-1:0] hs_cur;

    logic [DIV_PAD_W-1:0]  quo1;
    logic [DIV_STAGES-1:0] d1_valid_reg;
    s1_t                   d1_s1_reg [DIV_STAGES];

    logic                   b_valid_reg;
    s1_t                    b_s1_reg;
    logic [H_W-1:0]         b_h_reg;
    logic signed [TOP_W-1:0] b_top_reg;
    logic [H_W-1:0]         b_h_next;
    logic signed [TOP_W-1:0] b_diff;
    logic signed [TOP_W-1:0] b_top_sum;

    logic                 c_valid_reg;
    ctx_t                 c_ctx_reg;
    logic [H_W-1:0]       c_h_reg;
    logic [DIV_NUM_W-1:0] c_num_reg;
    ctx_t                 c_ctx_next;
    logic [DIV_NUM_W-1:0] c_num_next;
    logic signed [CMP_W-1:0] c_row;
    logic signed [CMP_W-1:0] c_top;
    logic signed [CMP_W-1:0] c_hgt;
    logic signed [CMP_W-1:0] c_last_row;
    logic signed [CMP_W-1:0] c_rowoff;
    logic [TXP_W-1:0]        c_tx_prod;
    logic [TXP_W-17:0]       c_tx_full;
    logic                    c_has_slot;

    logic [DIV_PAD_W-1:0]  quo2;
    logic [DIV_STAGES-1:0] d2_valid_reg;
    ctx_t                  d2_ctx_reg [DIV_STAGES];

    logic              d_valid_reg;
    ctx_t              d_ctx_reg;
    logic [ADDR_W-1:0] d_rd_addr_reg;
    logic [ADDR_W-1:0] d_wr_addr_reg;
    logic              d_wr_en_reg;
    ctx_t              d_ctx_in;
    logic [TY_W-1:0]   d_ty;
    logic [ADDR_W-1:0] d_rd_addr_next;
    logic [ADDR_W-1:0] d_wr_addr_next;
    logic              d_wr_ok;

    logic               e_valid_reg;
    ctx_t               e_ctx_reg;
    logic [TEXEL_W-1:0] e_texel;
    logic [TEXEL_W-1:0] e_rgb;
    logic               produce;
    wcts_out_t          produce_data;

    logic      m_valid_reg;
    wcts_out_t m_data_reg;
    logic      skid_valid_reg;
    wcts_out_t skid_data_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_screen_height_reg <= RESET_SCREEN_HEIGHT;
            cfg_wall_scale_reg    <= RESET_WALL_SCALE;
            cfg_texture_count_reg <= RESET_TEXTURE_COUNT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCREEN_HEIGHT: cfg_screen_height_reg <= SCREEN_HEIGHT_W'(cfg_data);
                CFG_WALL_SCALE:    cfg_wall_scale_reg    <= cfg_data[WALL_SCALE_W-1:0];
                CFG_TEXTURE_COUNT: cfg_texture_count_reg <= cfg_data[TEXTURE_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // stage A: capture item
    assign hs_cur = (int'(cfg_screen_height_reg) > MAX_ROWS) ? HS_W'(MAX_ROWS)
                                                             : HS_W'(cfg_screen_height_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_s1_reg.item <= s_data;
            a_s1_reg.hs   <= hs_cur;
            a_s1_reg.near <= (s_data.distance <= NEAR_LIMIT);
        end
    end

    // wall height division
    wcts_divider u_height_div (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (DIV_NUM_W'({cfg_wall_scale_reg, 8'h00})),
        .den  (H_W'(a_s1_reg.item.distance)),
        .quo  (quo1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= '0;
        end else if (pipe_en) begin
            d1_valid_reg <= {d1_valid_reg[DIV_STAGES-2:0], a_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d1_s1_reg[0] <= a_s1_reg;
            for (int s = 1; s < DIV_STAGES; s++) begin
                d1_s1_reg[s] <= d1_s1_reg[s-1];
            end
        end
    end

    // stage B: height and top row
    always_comb begin
        b_h_next  = d1_s1_reg[DIV_STAGES-1].near
                  ? H_W'(d1_s1_reg[DIV_STAGES-1].hs) << 1
                  : quo1[H_W-1:0];
        b_diff    = TOP_W'(d1_s1_reg[DIV_STAGES-1].hs) - TOP_W'(b_h_next);
        b_top_sum = b_diff + TOP_W'(b_diff[TOP_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            b_valid_reg <= d1_valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_s1_reg  <= d1_s1_reg[DIV_STAGES-1];
            b_h_reg   <= b_h_next;
            b_top_reg <= b_top_sum >>> 1;
        end
    end

    // stage C: span test, texture column, slot
    always_comb begin
        c_row      = CMP_W'(b_s1_reg.item.row);
        c_top      = CMP_W'(b_top_reg);
        c_hgt      = CMP_W'(b_h_reg);
        c_last_row = CMP_W'(b_s1_reg.hs) - CMP_W'(1);
        c_rowoff   = c_row - c_top;
        c_num_next = DIV_NUM_W'(c_rowoff[H_W-1:0]) * DIV_NUM_W'(TEX_HEIGHT);
        c_tx_prod  = TXP_W'(b_s1_reg.item.wall_u) * TXP_W'(TEX_WIDTH);
        c_tx_full  = c_tx_prod[TXP_W-1:16];
        c_has_slot = (b_s1_reg.item.wall_type == WALL_BRICK)
                  || (b_s1_reg.item.wall_type == WALL_STONE);

        c_ctx_next.cmd   = b_s1_reg.item.cmd;
        c_ctx_next.column = b_s1_reg.item.column;
        c_ctx_next.row   = b_s1_reg.item.row;
        c_ctx_next.vface = b_s1_reg.item.vertical_face;
        c_ctx_next.tsel  = b_s1_reg.item.tex_select;
        c_ctx_next.tcol  = b_s1_reg.item.tex_col;
        c_ctx_next.trow  = b_s1_reg.item.tex_row;
        c_ctx_next.texel = b_s1_reg.item.texel;
        c_ctx_next.slot  = (b_s1_reg.item.wall_type == WALL_STONE);
        c_ctx_next.grey  = !c_has_slot
                        || (TEXTURE_COUNT_W'(c_ctx_next.slot) >= cfg_texture_count_reg)
                        || (int'(c_ctx_next.slot) >= TEXTURE_SLOTS);
        c_ctx_next.tx    = (int'(c_tx_full) > TEX_WIDTH - 1) ? TX_W'(TEX_WIDTH - 1)
                                                             : TX_W'(c_tx_full);
        c_ctx_next.draw  = (b_s1_reg.item.cmd == CMD_PIXEL)
                        && (c_row >= c_top)
                        && (c_row <= c_top + c_hgt)
                        && (c_row <= c_last_row);
        c_ctx_next.hzero = (b_h_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c_ctx_reg <= c_ctx_next;
            c_h_reg   <= b_h_reg;
            c_num_reg <= c_num_next;
        end
    end

    // texture row division
    wcts_divider u_texy_div (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (c_num_reg),
        .den  (c_h_reg),
        .quo  (quo2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_valid_reg <= '0;
        end else if (pipe_en) begin
            d2_valid_reg <= {d2_valid_reg[DIV_STAGES-2:0], c_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d2_ctx_reg[0] <= c_ctx_reg;
            for (int s = 1; s < DIV_STAGES; s++) begin
                d2_ctx_reg[s] <= d2_ctx_reg[s-1];
            end
        end
    end

    // stage D: store addresses
    always_comb begin
        d_ctx_in = d2_ctx_reg[DIV_STAGES-1];
        if (d_ctx_in.hzero) begin
            d_ty = '0;
        end else if (quo2 > DIV_PAD_W'(TEX_HEIGHT - 1)) begin
            d_ty = TY_W'(TEX_HEIGHT - 1);
        end else begin
            d_ty = quo2[TY_W-1:0];
        end
        d_rd_addr_next = ADDR_W'(int'(d_ctx_in.slot) * TEX_HEIGHT * TEX_WIDTH
                       + int'(d_ty) * TEX_WIDTH + int'(d_ctx_in.tx));
        d_wr_addr_next = ADDR_W'(int'(d_ctx_in.tsel) * TEX_HEIGHT * TEX_WIDTH
                       + int'(d_ctx_in.trow) * TEX_WIDTH + int'(d_ctx_in.tcol));
        d_wr_ok = (d_ctx_in.cmd == CMD_TEXEL)
               && (int'(d_ctx_in.tcol) < TEX_WIDTH)
               && (int'(d_ctx_in.trow) < TEX_HEIGHT)
               && (int'(d_ctx_in.tsel) < TEXTURE_SLOTS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            d_wr_en_reg <= 1'b0;
        end else if (pipe_en) begin
            d_valid_reg <= d2_valid_reg[DIV_STAGES-1];
            d_wr_en_reg <= d2_valid_reg[DIV_STAGES-1] && d_wr_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d_ctx_reg     <= d_ctx_in;
            d_rd_addr_reg <= d_rd_addr_next;
            d_wr_addr_reg <= d_wr_addr_next;
        end
    end

    wcts_tex_mem u_tex_mem (
        .aclk    (aclk),
        .en      (pipe_en),
        .wr_en   (d_wr_en_reg),
        .wr_addr (d_wr_addr_reg),
        .wr_data (d_ctx_reg.texel),
        .rd_addr (d_rd_addr_reg),
        .rd_data (e_texel)
    );

    // stage E: shade
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            e_ctx_reg <= d_ctx_reg;
        end
    end

    always_comb begin
        if (e_ctx_reg.grey) begin
            e_rgb = GREY_RGB;
        end else if (e_ctx_reg.vface) begin
            e_rgb = e_texel;
        end else begin
            e_rgb = (e_texel >> 1) & HALF_MASK;
        end
        produce                  = pipe_en && e_valid_reg && e_ctx_reg.draw;
        produce_data.out_column  = e_ctx_reg.column;
        produce_data.out_row     = e_ctx_reg.row;
        produce_data.pixel_color = {ALPHA_OPAQUE, e_rgb};
    end

    // output register and skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= produce;
        end else if (produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_data_reg <= produce_data;
        end else if (produce) begin
            skid_data_reg <= produce_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid entry filled without a stalled output");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(e_valid_reg) && $stable(d_valid_reg) && $stable(c_valid_reg))
        else $error("pipeline moved during a stall");

endmodule

// ----- sv/wcts_divider.sv -----
// ----------------------------------------------------------------------------
// wcts_divider
// Pipelined restoring divider, two quotient bits per stage, stalls on en.
// ----------------------------------------------------------------------------
module wcts_divider import wcts_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [H_W-1:0]       den,
    output logic [DIV_PAD_W-1:0] quo
);

    logic [H_W-1:0]       rem_reg  [DIV_STAGES];
    logic [DIV_PAD_W-1:0] bits_reg [DIV_STAGES];
    logic [DIV_PAD_W-1:0] quo_reg  [DIV_STAGES];
    logic [H_W-1:0]       den_reg  [DIV_STAGES];

    logic [H_W-1:0]       rem_next  [DIV_STAGES];
    logic [DIV_PAD_W-1:0] bits_next [DIV_STAGES];
    logic [DIV_PAD_W-1:0] quo_next  [DIV_STAGES];

    logic [H_W-1:0]       src_rem  [DIV_STAGES];
    logic [DIV_PAD_W-1:0] src_bits [DIV_STAGES];
    logic [DIV_PAD_W-1:0] src_quo  [DIV_STAGES];
    logic [H_W-1:0]       src_den  [DIV_STAGES];

    always_comb begin
        src_rem[0]  = '0;
        src_bits[0] = DIV_PAD_W'(num);
        src_quo[0]  = '0;
        src_den[0]  = den;
        for (int s = 1; s < DIV_STAGES; s++) begin
            src_rem[s]  = rem_reg[s-1];
            src_bits[s] = bits_reg[s-1];
            src_quo[s]  = quo_reg[s-1];
            src_den[s]  = den_reg[s-1];
        end
    end

    always_comb begin
        logic [H_W-1:0]       rem;
        logic [DIV_PAD_W-1:0] bits;
        logic [DIV_PAD_W-1:0] q;
        logic [H_W:0]         trial;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem  = src_rem[s];
            bits = src_bits[s];
            q    = src_quo[s];
            for (int k = 0; k < DIV_STEP_BITS; k++) begin
                trial = {rem, bits[DIV_PAD_W-1]};
                bits  = bits << 1;
                if (trial >= {1'b0, src_den[s]}) begin
                    rem = H_W'(trial - {1'b0, src_den[s]});
                    q   = {q[DIV_PAD_W-2:0], 1'b1};
                end else begin
                    rem = trial[H_W-1:0];
                    q   = {q[DIV_PAD_W-2:0], 1'b0};
                end
            end
            rem_next[s]  = rem;
            bits_next[s] = bits;
            quo_next[s]  = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                rem_reg[s]  <= rem_next[s];
                bits_reg[s] <= bits_next[s];
                quo_reg[s]  <= quo_next[s];
                den_reg[s]  <= src_den[s];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// ----- sv/wcts_tex_mem.sv -----
// ----------------------------------------------------------------------------
// wcts_tex_mem
// Texel store: one write port, one registered read port, both held on stall.
// ----------------------------------------------------------------------------
module wcts_tex_mem import wcts_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [TEXEL_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [TEXEL_W-1:0] rd_data
);

    logic [TEXEL_W-1:0] mem [STORE_DEPTH];
    logic [TEXEL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (en && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- verif/tb_wall_column_texture_shader.sv -----
// ----------------------------------------------------------------------------
// tb_wall_column_texture_shader
// Self-checking bench for the wall column texture shader. A short table of
// texel loads and pixel items comes first, then register sweeps with random
// pixels aimed at each wall span and random texel writes. A shading predictor
// and texel store mirror track every accepted item. Results are compared in
// order against it, under random backpressure and sender gaps in most phases.
// ----------------------------------------------------------------------------
module tb_wall_column_texture_shader;
    import wcts_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int PIPE_LATENCY = 31;
    localparam int QUIET_CYCLES = PIPE_LATENCY + 16;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASES       = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {ROW_DRAWN, ROW_SKIPPED, ROW_PREDICTED} row_check_e;

    typedef struct packed {
        logic                  tex_select;
        logic [TEXCOORD_W-1:0] tex_col;
        logic [TEXCOORD_W-1:0] tex_row;
        logic [TEXEL_W-1:0]    texel;
    } texel_row_t;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic [DIST_W-1:0]   distance;
        logic [WALL_U_W-1:0] wall_u;
        logic [WTYPE_W-1:0]  wall_type;
        logic                vertical_face;
        row_check_e          check;
        logic [COLOR_W-1:0]  color;
    } pixel_row_t;

    typedef struct packed {
        logic [SCREEN_HEIGHT_W-1:0] screen_height;
        logic [WALL_SCALE_W-1:0]    wall_scale;
        logic [TEXTURE_COUNT_W-1:0] texture_count;
    } shade_setting_t;

    typedef struct {
        bit drawn;
        bit textured;
        int addr;
    } pixel_plan_t;

    localparam texel_row_t TEXEL_ROWS [4] = '{
        '{1'b0, 6'd0,  6'd16, 24'hFFFFFF},
        '{1'b1, 6'd63, 6'd63, 24'h123456},
        '{1'b0, 6'd63, 6'd0,  24'hA5C3E1},
        '{1'b1, 6'd0,  6'd0,  24'h010203}
    };

    localparam pixel_row_t PIXEL_ROWS [19] = '{
        '{10'd0,    10'd0,    16'd0,     16'h0000, WALL_BRICK, 1'b1, ROW_DRAWN, 32'hFFFFFFFF},
        '{10'd1023, 10'd0,    16'd0,     16'h0000, WALL_BRICK, 1'b0, ROW_DRAWN, 32'hFF7F7F7F},
        '{10'd5,    10'd1023, 16'd0,     16'h0000, WALL_BRICK, 1'b1, ROW_SKIPPED, 32'h0},
        '{10'd6,    10'd479,  16'd3,     16'h0000, 8'd0,       1'b1, ROW_DRAWN, 32'hFF646464},
        '{10'd7,    10'd480,  16'd3,     16'h0000, 8'd0,       1'b1, ROW_SKIPPED, 32'h0},
        '{10'd8,    10'd240,  16'hFFFF,  16'hFFFF, WALL_STONE, 1'b1, ROW_DRAWN, 32'hFF123456},
        '{10'd9,    10'd239,  16'hFFFF,  16'hFFFF, WALL_BRICK, 1'b1, ROW_DRAWN, 32'hFFA5C3E1},
        '{10'd9,    10'd239,  16'hFFFF,  16'hFFFF, WALL_BRICK, 1'b0, ROW_DRAWN, 32'hFF526170},
        '{10'd10,   10'd238,  16'hFFFF,  16'hFFFF, WALL_BRICK, 1'b1, ROW_SKIPPED, 32'h0},
        '{10'd11,   10'd241,  16'hFFFF,  16'hFFFF, WALL_BRICK, 1'b1, ROW_SKIPPED, 32'h0},
        '{10'd12,   10'd60,   16'd256,   16'h0000, WALL_STONE, 1'b1, ROW_DRAWN, 32'hFF010203},
        '{10'd13,   10'd420,  16'd256,   16'h0000, 8'd255,     1'b0, ROW_DRAWN, 32'hFF646464},
        '{10'd14,   10'd421,  16'd256,   16'h0000, 8'd3,       1'b1, ROW_SKIPPED, 32'h0},
        '{10'd15,   10'd59,   16'd256,   16'h0000, WALL_BRICK, 1'b1, ROW_SKIPPED, 32'h0},
        '{10'd16,   10'd0,    16'd4,     16'h0000, 8'd7,       1'b0, ROW_DRAWN, 32'hFF646464},
        '{10'd100,  10'd300,  16'h0180,  16'h8000, WALL_BRICK, 1'b1, ROW_PREDICTED, 32'h0},
        '{10'd512,  10'd200,  16'h0400,  16'h4321, WALL_STONE, 1'b0, ROW_PREDICTED, 32'h0},
        '{10'd333,  10'd250,  16'h1000,  16'hC000, WALL_BRICK, 1'b0, ROW_PREDICTED, 32'h0},
        '{10'd700,  10'd100,  16'h0010,  16'h0001, WALL_STONE, 1'b1, ROW_PREDICTED, 32'h0}
    };

    localparam shade_setting_t SWEEP [PHASES] = '{
        '{11'd480,  12'd360,  2'd2},
        '{11'd1024, 12'd4095, 2'd3},
        '{11'd1,    12'd1,    2'd0},
        '{11'd2047, 12'd200,  2'd1},
        '{11'd0,    12'd360,  2'd2},
        '{11'd240,  12'd4095, 2'd2},
        '{11'd1023, 12'd1,    2'd3},
        '{11'd600,  12'd1500, 2'd2},
        '{11'd768,  12'd64,   2'd1}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    wcts_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    wcts_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SCREEN_HEIGHT;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [SCREEN_HEIGHT_W-1:0] screen_rows  = RESET_SCREEN_HEIGHT;
    logic [WALL_SCALE_W-1:0]    wall_scale   = RESET_WALL_SCALE;
    logic [TEXTURE_COUNT_W-1:0] loaded_slots = RESET_TEXTURE_COUNT;

    logic [TEXEL_W-1:0] texel_mem   [STORE_DEPTH];
    bit                 texel_known [STORE_DEPTH];

    wcts_out_t pixel_queue [$];
    wcts_out_t oldest;

    int send_gap_pct   = 9;
    int recv_stall_pct = 78;
    int mismatches     = 0;
    int items_sent     = 0;
    int pixels_checked = 0;
    int texel_writes   = 0;
    int cycles_run     = 0;

    wall_column_texture_shader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    function automatic void wall_span(input logic [DIST_W-1:0] ray_dist, output longint top,
                                      output longint h, output longint first,
                                      output longint last);
        longint rows;
        rows = (screen_rows > MAX_ROWS) ? longint'(MAX_ROWS) : longint'(screen_rows);
        if (ray_dist <= NEAR_LIMIT) begin
            h = 2 * rows;
        end else begin
            h = (longint'(wall_scale) * 256) / longint'(ray_dist);
        end
        top   = (rows - h) / 2;
        first = (top > 0) ? top : 0;
        last  = (top + h < rows - 1) ? top + h : rows - 1;
    endfunction

    function automatic pixel_plan_t plan_pixel(input wcts_in_t it);
        pixel_plan_t plan;
        longint      top, h, first, last, tx, ty;
        int          slot;
        wall_span(it.distance, top, h, first, last);
        plan.drawn = longint'(it.row) >= first && longint'(it.row) <= last;
        slot = -1;
        if (it.wall_type == WALL_BRICK) begin
            slot = 0;
        end else if (it.wall_type == WALL_STONE) begin
            slot = 1;
        end
        plan.textured = plan.drawn && slot >= 0 && slot < int'(loaded_slots)
                        && slot < TEXTURE_SLOTS;
        plan.addr = 0;
        if (plan.textured) begin
            tx = (longint'(it.wall_u) * TEX_WIDTH) >>> 16;
            if (tx > TEX_WIDTH - 1) begin
                tx = TEX_WIDTH - 1;
            end
            ty = 0;
            if (h > 0) begin
                ty = ((longint'(it.row) - top) * TEX_HEIGHT) / h;
                if (ty > TEX_HEIGHT - 1) begin
                    ty = TEX_HEIGHT - 1;
                end
            end
            plan.addr = int'((slot * TEX_HEIGHT + ty) * TEX_WIDTH + tx);
        end
        return plan;
    endfunction

    function automatic wcts_out_t shade_pixel(input wcts_in_t it, input pixel_plan_t plan);
        logic [TEXEL_W-1:0] rgb;
        wcts_out_t          px;
        rgb = GREY_RGB;
        if (plan.textured) begin
            rgb = texel_mem[plan.addr];
            if (!it.vertical_face) begin
                rgb = (rgb >> 1) & HALF_MASK;
            end
        end
        px.out_column  = it.column;
        px.out_row     = it.row;
        px.pixel_color = {ALPHA_OPAQUE, rgb};
        return px;
    endfunction

    function automatic void store_texel(input wcts_in_t it);
        int addr;
        addr = (int'(it.tex_select) * TEX_HEIGHT + int'(it.tex_row)) * TEX_WIDTH
               + int'(it.tex_col);
        texel_mem[addr]   = it.texel;
        texel_known[addr] = 1'b1;
        texel_writes++;
    endfunction

    function automatic wcts_in_t noise_item();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return wcts_in_t'(bits[$bits(wcts_in_t)-1:0]);
    endfunction

    function automatic wcts_in_t random_pixel();
        wcts_in_t it;
        longint   top, h, first, last;
        it = noise_item();
        it.cmd = CMD_PIXEL;
        case ($urandom_range(9))
            0:       it.distance = DIST_W'($urandom_range(3));
            1:       it.distance = DIST_W'($urandom_range(64, 4));
            2, 3:    it.distance = DIST_W'($urandom_range(1024, 64));
            4, 5:    it.distance = DIST_W'($urandom_range(4096, 256));
            6:       it.distance = it.distance;
            default: it.distance = DIST_W'($urandom_range(65535, 1024));
        endcase
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: it.wall_type = WALL_BRICK;
            9, 10, 11, 12, 13, 14, 15, 16: it.wall_type = WALL_STONE;
            default: it.wall_type = it.wall_type;
        endcase
        wall_span(it.distance, top, h, first, last);
        if (first <= last && $urandom_range(99) < 85) begin
            it.row = ROW_W'($urandom_range(32'(last), 32'(first)));
        end
        return it;
    endfunction

    task automatic offer(input wcts_in_t it);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic load_texel(input int addr);
        wcts_in_t it;
        it = noise_item();
        it.cmd        = CMD_TEXEL;
        it.tex_select = 1'(addr / (TEX_WIDTH * TEX_HEIGHT));
        it.tex_row    = TEXCOORD_W'((addr / TEX_WIDTH) % TEX_HEIGHT);
        it.tex_col    = TEXCOORD_W'(addr % TEX_WIDTH);
        offer(it);
        store_texel(it);
    endtask

    task automatic send_item(input wcts_in_t it, input row_check_e check,
                             input logic [COLOR_W-1:0] color);
        pixel_plan_t plan;
        plan = '{default: 0};
        if (it.cmd == CMD_PIXEL) begin
            plan = plan_pixel(it);
            if (plan.textured && !texel_known[plan.addr]) begin
                load_texel(plan.addr);
            end
        end
        offer(it);
        if (it.cmd == CMD_TEXEL) begin
            store_texel(it);
        end else begin
            case (check)
                ROW_DRAWN:     pixel_queue.push_back('{it.column, it.row, color});
                ROW_PREDICTED: if (plan.drawn) pixel_queue.push_back(shade_pixel(it, plan));
                default:       ;
            endcase
        end
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixel_queue.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pixel_queue.size() != 0) begin
            flag_error($sformatf("%0d expected pixels never arrived", pixel_queue.size()));
            pixel_queue.delete();
        end
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input shade_setting_t s);
        logic [CFG_INDEX_W-1:0] order [4];
        logic [CFG_DATA_W-1:0]  value;
        order = '{CFG_WALL_SCALE, CFG_SPARE, CFG_SCREEN_HEIGHT, CFG_TEXTURE_COUNT};
        foreach (order[k]) begin
            case (order[k])
                CFG_SCREEN_HEIGHT: value = {1'($urandom), s.screen_height};
                CFG_WALL_SCALE:    value = s.wall_scale;
                CFG_TEXTURE_COUNT: value = {10'($urandom), s.texture_count};
                default:           value = CFG_DATA_W'($urandom);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= value;
            @(posedge aclk);
            while (!cfg_ready) begin
                @(posedge aclk);
            end
            case (order[k])
                CFG_SCREEN_HEIGHT: screen_rows  = value[SCREEN_HEIGHT_W-1:0];
                CFG_WALL_SCALE:    wall_scale   = value[WALL_SCALE_W-1:0];
                CFG_TEXTURE_COUNT: loaded_slots = value[TEXTURE_COUNT_W-1:0];
                default:           ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pixel_queue.size() == 0) begin
                flag_error($sformatf("unexpected pixel col %0d row %0d color %h",
                                     m_data.out_column, m_data.out_row, m_data.pixel_color));
            end else begin
                oldest = pixel_queue.pop_front();
                pixels_checked++;
                if (m_data.out_column !== oldest.out_column ||
                    m_data.out_row !== oldest.out_row ||
                    m_data.pixel_color !== oldest.pixel_color) begin
                    flag_error($sformatf(
                        "pixel %0d mismatch: col %0d/%0d row %0d/%0d color %h/%h (exp/got)",
                        pixels_checked, oldest.out_column, m_data.out_column,
                        oldest.out_row, m_data.out_row, oldest.pixel_color,
                        m_data.pixel_color));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        wcts_in_t it;
        int       phase_end;
        int       phase_mid;
        bit       held;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (TEXEL_ROWS[i]) begin
            it = '0;
            it.cmd        = CMD_TEXEL;
            it.tex_select = TEXEL_ROWS[i].tex_select;
            it.tex_col    = TEXEL_ROWS[i].tex_col;
            it.tex_row    = TEXEL_ROWS[i].tex_row;
            it.texel      = TEXEL_ROWS[i].texel;
            send_item(it, ROW_SKIPPED, '0);
        end
        foreach (PIXEL_ROWS[i]) begin
            it = '0;
            it.cmd           = CMD_PIXEL;
            it.column        = PIXEL_ROWS[i].column;
            it.row           = PIXEL_ROWS[i].row;
            it.distance      = PIXEL_ROWS[i].distance;
            it.wall_u        = PIXEL_ROWS[i].wall_u;
            it.wall_type     = PIXEL_ROWS[i].wall_type;
            it.vertical_face = PIXEL_ROWS[i].vertical_face;
            send_item(it, PIXEL_ROWS[i].check, PIXEL_ROWS[i].color);
        end
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 3)
                0:       begin send_gap_pct = 9;  recv_stall_pct = 78; end
                1:       begin send_gap_pct = 78; recv_stall_pct = 9;  end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            apply_setting(SWEEP[phase]);
            phase_end = items_sent + ((SWEEP[phase].screen_height == 0) ? 60 : 195);
            phase_mid = phase_end - 90;
            held = (phase % 2 == 0);
            while (items_sent < phase_end) begin
                if (!held && items_sent >= phase_mid) begin
                    settle();
                    held = 1'b1;
                end
                if ($urandom_range(99) < 20) begin
                    it = noise_item();
                    it.cmd = CMD_TEXEL;
                end else begin
                    it = random_pixel();
                end
                send_item(it, ROW_PREDICTED, '0);
            end
            settle();
        end

        $display("shaded %0d pixels from %0d items, %0d of them texel writes, in %0d cycles",
                 pixels_checked, items_sent, texel_writes, cycles_run);
        $display("swept %0d register settings: near-wall clamp, zero height, empty span, grey",
                 PHASES);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
